[rtl/sfp_pkg.sv]
// ---------------------------------------------------------------------------
// sfp_pkg: shared types and constants for the status frame parser
// Holds the frame phase encoding, configuration and result bundles.
// ---------------------------------------------------------------------------
package sfp_pkg;

  localparam int PAYLOAD_LEN = 4;
  localparam int STORE_DEPTH = 4;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int IDX_W       = 5;

  localparam logic [7:0] STATUS_LIMIT = 8'h01;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER   = 2'd0;
  localparam logic [1:0] REG_ADDRESS  = 2'd1;
  localparam logic [1:0] REG_FUNCTION = 2'd2;
  localparam logic [1:0] REG_TAIL     = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ADDRESS  = 3'd1,
    PH_FUNCTION = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_SUM      = 3'd5,
    PH_TAIL     = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] address_byte;
    logic [7:0] function_byte;
    logic [7:0] tail_byte;
  } sfp_cfg_t;

  typedef struct packed {
    logic        frame_fault;
    logic        speed_valid;
    logic [15:0] speed;
    logic        fault_latched;
  } sfp_result_t;

endpackage

[rtl/status_frame_parser_top.sv]
// ---------------------------------------------------------------------------
// status_frame_parser_top: byte-serial status frame parser
// Parses header, address, function, length, payload, 16-bit sum and tail,
// reporting faults and speeds from completed frames.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  -----------------------------------
//  in       sink       in_valid / in_stall  rx_byte
//  out      source     out_valid/out_stall  frame_fault, speed_valid, speed,
//                                           fault_latched
//  cfg      sink       cfg_we               cfg_index, cfg_data
//
//  One byte transfers per cycle when the output is taken; a byte passes
//  through the input register, the phase machine and the result register.
//  Synchronous reset clears the phase machine, sum, last speed, fault flag,
//  configuration registers and both pipeline valids.
//  A stalled result holds in the result register; the input register still
//  takes one more byte, and in_stall rises only once both stages are full.
// ---------------------------------------------------------------------------
module status_frame_parser_top (
  input  logic        clk,
  input  logic        rst,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_fault,
  output logic        speed_valid,
  output logic [15:0] speed,
  output logic        fault_latched,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  sfp_pkg::sfp_cfg_t    cfg;
  sfp_pkg::sfp_result_t core_result;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       advance;
  logic       in_take;

  // Move the held byte into the result stage when the result register is
  // empty or being taken this cycle.
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers: written only while idle (user rule, unenforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfp_pkg::REG_HEADER:   cfg.header_byte   <= cfg_data;
        sfp_pkg::REG_ADDRESS:  cfg.address_byte  <= cfg_data;
        sfp_pkg::REG_FUNCTION: cfg.function_byte <= cfg_data;
        sfp_pkg::REG_TAIL:     cfg.tail_byte     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: hold the byte until the phase machine takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte <= rx_byte;
    end
  end

  sfp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .data    (stage_byte),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Result register: every byte yields exactly one result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_fault   <= core_result.frame_fault;
      speed_valid   <= core_result.speed_valid;
      speed         <= core_result.speed;
      fault_latched <= core_result.fault_latched;
    end
  end

endmodule

[rtl/sfp_core.sv]
// ---------------------------------------------------------------------------
// sfp_core: frame phase machine of the status frame parser
// Consumes one byte when advance is high and produces that byte's result.
// ---------------------------------------------------------------------------
module sfp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          data,
  input  sfp_pkg::sfp_cfg_t   cfg,
  output sfp_pkg::sfp_result_t result
);

  sfp_pkg::phase_t              phase, phase_next;
  logic [sfp_pkg::IDX_W-1:0]    byte_index, byte_index_next;
  logic [15:0]                  sum_acc, sum_acc_next;
  logic [7:0]                   sum_high, sum_high_next;
  logic [15:0]                  last_speed, last_speed_next;
  logic                         fault_flag, fault_flag_next;
  logic [7:0]                   payload_store [sfp_pkg::STORE_DEPTH];
  logic                         store_we;
  logic                         fault_now, valid_now;
  logic [sfp_pkg::IDX_W-1:0]    idx_inc;
  logic [15:0]                  sum_add;

  assign idx_inc = byte_index + sfp_pkg::IDX_W'(1);
  assign sum_add = sum_acc + {8'h00, data};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sfp_pkg::PH_HEADER;
      byte_index <= '0;
      sum_acc    <= '0;
      last_speed <= '0;
      fault_flag <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      sum_acc    <= sum_acc_next;
      last_speed <= last_speed_next;
      fault_flag <= fault_flag_next;
    end
  end

  // Payload and received sum byte need no reset: written before read
  always_ff @(posedge clk) begin
    if (advance) begin
      sum_high <= sum_high_next;
      if (store_we) begin
        payload_store[byte_index[sfp_pkg::STORE_AW-1:0]] <= data;
      end
    end
  end

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    sum_acc_next    = sum_acc;
    sum_high_next   = sum_high;
    last_speed_next = last_speed;
    fault_flag_next = fault_flag;
    store_we        = 1'b0;
    fault_now       = 1'b0;
    valid_now       = 1'b0;
    case (phase)
      sfp_pkg::PH_ADDRESS: begin
        phase_next = (data == cfg.address_byte) ? sfp_pkg::PH_FUNCTION : sfp_pkg::PH_HEADER;
      end
      sfp_pkg::PH_FUNCTION: begin
        if (data == cfg.function_byte) begin
          sum_acc_next = sum_add;
          phase_next   = sfp_pkg::PH_LENGTH;
        end else begin
          sum_acc_next = '0;
          phase_next   = sfp_pkg::PH_HEADER;
        end
      end
      sfp_pkg::PH_LENGTH: begin
        if (data == 8'(sfp_pkg::PAYLOAD_LEN)) begin
          sum_acc_next    = sum_add;
          byte_index_next = '0;
          phase_next      = sfp_pkg::PH_PAYLOAD;
        end else begin
          sum_acc_next = '0;
          phase_next   = sfp_pkg::PH_HEADER;
        end
      end
      sfp_pkg::PH_PAYLOAD: begin
        store_we     = (byte_index < sfp_pkg::IDX_W'(sfp_pkg::STORE_DEPTH));
        sum_acc_next = sum_add;
        if (idx_inc >= sfp_pkg::IDX_W'(sfp_pkg::PAYLOAD_LEN)) begin
          byte_index_next = '0;
          phase_next      = sfp_pkg::PH_SUM;
        end else begin
          byte_index_next = idx_inc;
        end
      end
      sfp_pkg::PH_SUM: begin
        if (byte_index == '0) begin
          sum_high_next   = data;
          byte_index_next = sfp_pkg::IDX_W'(1);
        end else begin
          phase_next = ((sum_high == sum_acc[15:8]) && (data == sum_acc[7:0])) ?
                       sfp_pkg::PH_TAIL : sfp_pkg::PH_HEADER;
          byte_index_next = '0;
          sum_acc_next    = '0;
        end
      end
      sfp_pkg::PH_TAIL: begin
        if (data == cfg.tail_byte) begin
          if (payload_store[0] > sfp_pkg::STATUS_LIMIT) begin
            fault_flag_next = 1'b1;
            fault_now       = 1'b1;
          end else begin
            last_speed_next = {payload_store[2], payload_store[3]};
            valid_now       = 1'b1;
          end
        end
        phase_next = sfp_pkg::PH_HEADER;
      end
      default: begin
        // Header search, also taken by any unused phase code
        phase_next      = (data == cfg.header_byte) ? sfp_pkg::PH_ADDRESS : sfp_pkg::PH_HEADER;
        sum_acc_next    = '0;
        byte_index_next = '0;
      end
    endcase
  end

  always_comb begin
    result.frame_fault   = fault_now;
    result.speed_valid   = valid_now;
    result.speed         = last_speed_next;
    result.fault_latched = fault_flag_next;
  end

endmodule

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for the status frame parser
// Drives received bytes through the valid/stall input channel, predicts
// every result with a behavioural copy of the frame parser and compares
// each result transfer field by field. A short table of directed bytes
// comes first, then randomised frames over several register settings and
// idling patterns.
// ---------------------------------------------------------------------------
module tb_top;
  import sfp_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int FRAME_BYTES     = 7 + PAYLOAD_LEN;
  localparam int NUM_PHASES      = 8;
  localparam int BYTES_PER_PHASE = 180;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One row of the directed table: the byte to send and, where it is
  // obvious, the result typed in by hand.
  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    sfp_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        frame_fault;
  logic        speed_valid;
  logic [15:0] speed;
  logic        fault_latched;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_HEADER;
  logic [7:0]  cfg_data = 8'h00;

  status_frame_parser_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_fault   (frame_fault),
    .speed_valid   (speed_valid),
    .speed         (speed),
    .fault_latched (fault_latched),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Parser model: its own copy of the registers and the frame state
  // -------------------------------------------------------------------------
  sfp_cfg_t        cfg_model;
  phase_t          frame_phase;
  logic [IDX_W-1:0] byte_pos;
  logic [7:0]      payload_copy [STORE_DEPTH];
  logic [15:0]     running_sum;
  logic [7:0]      sum_high_seen;
  logic [15:0]     speed_model;
  logic            fault_model;

  sfp_result_t     pending_results [$];
  stim_row_t       directed_rows [$];

  int              error_count = 0;
  int              quiet_cycles = 0;
  int              send_idle_pct = 0;
  int              stall_pct = 0;

  task automatic clear_parser_model();
    cfg_model     = '0;
    frame_phase   = PH_HEADER;
    byte_pos      = '0;
    running_sum   = '0;
    sum_high_seen = '0;
    speed_model   = '0;
    fault_model   = 1'b0;
    foreach (payload_copy[i]) payload_copy[i] = '0;
  endtask

  // Advance the frame state by one received byte and return the result the
  // block should give for it.
  function automatic sfp_result_t parse_byte(input logic [7:0] b);
    sfp_result_t r;
    logic        high_ok;
    logic        low_ok;
    r = '0;
    case (frame_phase)
      PH_ADDRESS: begin
        // a mismatching byte is dropped, not re-tried as a header
        frame_phase = (b == cfg_model.address_byte) ? PH_FUNCTION : PH_HEADER;
      end
      PH_FUNCTION: begin
        if (b == cfg_model.function_byte) begin
          running_sum = running_sum + 16'(b);
          frame_phase = PH_LENGTH;
        end else begin
          running_sum = '0;
          frame_phase = PH_HEADER;
        end
      end
      PH_LENGTH: begin
        if (b == 8'(PAYLOAD_LEN)) begin
          running_sum = running_sum + 16'(b);
          byte_pos    = '0;
          frame_phase = PH_PAYLOAD;
        end else begin
          running_sum = '0;
          frame_phase = PH_HEADER;
        end
      end
      PH_PAYLOAD: begin
        // bytes past the store are summed only
        if (byte_pos < IDX_W'(STORE_DEPTH)) payload_copy[byte_pos[STORE_AW-1:0]] = b;
        running_sum = running_sum + 16'(b);
        byte_pos    = byte_pos + IDX_W'(1);
        if (byte_pos >= IDX_W'(PAYLOAD_LEN)) begin
          byte_pos    = '0;
          frame_phase = PH_SUM;
        end
      end
      PH_SUM: begin
        if (byte_pos == '0) begin
          sum_high_seen = b;
          byte_pos      = IDX_W'(1);
        end else begin
          high_ok     = (sum_high_seen == running_sum[15:8]);
          low_ok      = (b == running_sum[7:0]);
          frame_phase = (high_ok && low_ok) ? PH_TAIL : PH_HEADER;
          byte_pos    = '0;
          running_sum = '0;
        end
      end
      PH_TAIL: begin
        if (b == cfg_model.tail_byte) begin
          if (payload_copy[0] > STATUS_LIMIT) begin
            fault_model   = 1'b1;
            r.frame_fault = 1'b1;
          end else begin
            speed_model   = {payload_copy[2], payload_copy[3]};
            r.speed_valid = 1'b1;
          end
        end
        frame_phase = PH_HEADER;
      end
      default: begin
        frame_phase = (b == cfg_model.header_byte) ? PH_ADDRESS : PH_HEADER;
        running_sum = '0;
        byte_pos    = '0;
      end
    endcase
    r.speed         = speed_model;
    r.fault_latched = fault_model;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Random byte, weighted towards the two extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic stim_row_t plain_row(input logic [7:0] rx);
    stim_row_t s;
    s.rx    = rx;
    s.typed = 1'b0;
    s.res   = '0;
    return s;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] rx, input logic ff,
                                          input logic sv, input logic [15:0] spd,
                                          input logic fl);
    stim_row_t s;
    s.rx    = rx;
    s.typed = 1'b1;
    s.res   = '{frame_fault: ff, speed_valid: sv, speed: spd, fault_latched: fl};
    return s;
  endfunction

  // Offer one byte on the input channel and hold it until it transfers.
  // Idle cycles before the byte follow the current sender setting.
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input sfp_result_t typed_res);
    sfp_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      rx_byte  = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = parse_byte(b);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and wait for every predicted result to come back.
  task automatic await_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Full drain: results back, then let the pipeline settle.
  task automatic drain_block();
    await_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      REG_HEADER:   cfg_model.header_byte   = data;
      REG_ADDRESS:  cfg_model.address_byte  = data;
      REG_FUNCTION: cfg_model.function_byte = data;
      REG_TAIL:     cfg_model.tail_byte     = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [7:0] hdr, input logic [7:0] adr,
                           input logic [7:0] fn, input logic [7:0] tl);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_ADDRESS, adr);
    write_reg(REG_FUNCTION, fn);
    write_reg(REG_TAIL, tl);
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 74; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 74; end
      IDLE_BOTH:     begin send_idle_pct = 19; stall_pct = 19; end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Build one frame for the current registers with random content, break
  // it now and then, and send it, with a little line noise in front.
  task automatic send_frame(inout int byte_count);
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] sum;
    int          pos;
    sfp_result_t unused_res;
    unused_res = '0;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) send_byte(pick_byte(), 1'b0, unused_res);
    end
    fb[0] = cfg_model.header_byte;
    fb[1] = cfg_model.address_byte;
    fb[2] = cfg_model.function_byte;
    fb[3] = 8'(PAYLOAD_LEN);
    // status byte: mostly the two good values, sometimes a fault
    case ($urandom_range(3))
      0:       fb[4] = 8'h00;
      1:       fb[4] = 8'h01;
      default: fb[4] = pick_byte();
    endcase
    for (int i = 1; i < PAYLOAD_LEN; i++) fb[4 + i] = pick_byte();
    sum = '0;
    for (int i = 2; i < 4 + PAYLOAD_LEN; i++) sum = sum + 16'(fb[i]);
    fb[4 + PAYLOAD_LEN] = sum[15:8];
    fb[5 + PAYLOAD_LEN] = sum[7:0];
    fb[6 + PAYLOAD_LEN] = cfg_model.tail_byte;
    // break about one frame in four, either by a flipped bit or a new byte
    if ($urandom_range(99) < 25) begin
      pos = $urandom_range(FRAME_BYTES - 1);
      if ($urandom_range(1) == 0) fb[pos] = fb[pos] ^ 8'(1 << $urandom_range(7));
      else fb[pos] = pick_byte();
    end
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fb[i], 1'b0, unused_res);
    byte_count += FRAME_BYTES;
  endtask

  // -------------------------------------------------------------------------
  // Directed table. Results are typed in only where they are obvious: the
  // idle byte after reset and the two frame-ending tails.
  // -------------------------------------------------------------------------
  task automatic build_directed_rows();
    // idle byte straight after reset
    directed_rows.push_back(typed_row(8'h00, 1'b0, 1'b0, 16'h0000, 1'b0));
    // address mismatch on a header value: the second byte is not a header
    directed_rows.push_back(plain_row(8'hA5));
    directed_rows.push_back(plain_row(8'hA5));
    // length mismatch after a good function code
    directed_rows.push_back(plain_row(8'hA5));
    directed_rows.push_back(plain_row(8'h3C));
    directed_rows.push_back(plain_row(8'h81));
    directed_rows.push_back(plain_row(8'h05));
    // good frame with status 1 and the largest speed
    directed_rows.push_back(plain_row(8'hA5));
    directed_rows.push_back(plain_row(8'h3C));
    directed_rows.push_back(plain_row(8'h81));
    directed_rows.push_back(plain_row(8'h04));
    directed_rows.push_back(plain_row(8'h01));
    directed_rows.push_back(plain_row(8'h00));
    directed_rows.push_back(plain_row(8'hFF));
    directed_rows.push_back(plain_row(8'hFF));
    directed_rows.push_back(plain_row(8'h02));
    directed_rows.push_back(plain_row(8'h84));
    directed_rows.push_back(typed_row(8'h5A, 1'b0, 1'b1, 16'hFFFF, 1'b0));
    // faulting frame with status 0xFF: speed holds, flag latches
    directed_rows.push_back(plain_row(8'hA5));
    directed_rows.push_back(plain_row(8'h3C));
    directed_rows.push_back(plain_row(8'h81));
    directed_rows.push_back(plain_row(8'h04));
    directed_rows.push_back(plain_row(8'hFF));
    directed_rows.push_back(plain_row(8'h11));
    directed_rows.push_back(plain_row(8'h00));
    directed_rows.push_back(plain_row(8'h00));
    directed_rows.push_back(plain_row(8'h01));
    directed_rows.push_back(plain_row(8'h95));
    directed_rows.push_back(typed_row(8'h5A, 1'b1, 1'b0, 16'hFFFF, 1'b1));
  endtask

  // -------------------------------------------------------------------------
  // Receiver: stall at random, changing only on the falling edge
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // -------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest prediction
  // -------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    sfp_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_fault", 16'(want.frame_fault), 16'(frame_fault));
        check_field("speed_valid", 16'(want.speed_valid), 16'(speed_valid));
        check_field("speed", want.speed, speed);
        check_field("fault_latched", 16'(want.fault_latched), 16'(fault_latched));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: count cycles with no transfer on either channel
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("** status_frame_parser_top: FAILED **");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_sequence
    int          phase_bytes;
    bit          paused;

    clear_parser_model();
    build_directed_rows();
    set_idle_mode(IDLE_NONE);

    // hold reset, then release it between edges
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part: walk the table at full rate
    configure(8'hA5, 8'h3C, 8'h81, 8'h5A);
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);
    end
    drain_block();

    // random part: one register setting and idling pattern per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       configure(8'h00, 8'h00, 8'h00, 8'h00);
        1:       configure(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default: configure(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      endcase
      set_idle_mode(idle_mode_t'(p % 4));
      phase_bytes = 0;
      paused      = 1'b0;
      while (phase_bytes < BYTES_PER_PHASE) begin
        send_frame(phase_bytes);
        // halfway through, hold the sender until every result is back
        if (!paused && phase_bytes >= BYTES_PER_PHASE / 2) begin
          await_results();
          paused = 1'b1;
        end
      end
      drain_block();
    end

    if (error_count == 0) begin
      $display("** status_frame_parser_top: PASSED **");
    end else begin
      $display("** status_frame_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
